FILE: design/mbfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_pkg
// Shared types, constants and bit-count helpers for the memory bit flip
// statistics block.
// ----------------------------------------------------------------------------
package mbfs_pkg;

    localparam int WORD_BITS = 16;
    localparam int CNT_W     = 24;
    localparam int INC_W     = $clog2(WORD_BITS + 1);
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam longint MAX_WORDS = 524288;
    localparam longint CNT_LIMIT = MAX_WORDS * WORD_BITS;
    localparam longint FIELD_MAX = (longint'(1) << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_MAX =
        (CNT_LIMIT < FIELD_MAX) ? CNT_W'(CNT_LIMIT) : CNT_W'(FIELD_MAX);

    // compare modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ASCEND = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CENSUS = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_VALUE = 1'd1;

    // status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_REF = 1'b1;

    // queue between classifier and accumulator
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [INC_W-1:0] flip_one;
        logic [INC_W-1:0] flip_zero;
        logic [INC_W-1:0] ones;
        logic [INC_W-1:0] zeros;
        logic             no_ref;
        logic             last;
    } item_t;

    function automatic logic [INC_W-1:0] bits_set16(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] x;
        x = v;
        x = (x & 16'h5555) + ((x >> 1) & 16'h5555);
        x = (x & 16'h3333) + ((x >> 2) & 16'h3333);
        x = (x & 16'h0F0F) + ((x >> 4) & 16'h0F0F);
        x = (x & 16'h00FF) + ((x >> 8) & 16'h00FF);
        return x[INC_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                 input logic [INC_W-1:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, acc} + {{(CNT_W + 1 - INC_W){1'b0}}, inc};
        if (s > {1'b0, CNT_MAX})
        begin
            return CNT_MAX;
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

FILE: design/mbfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_front
// Holds the configuration and expected word, classifies each read word into
// per-word bit counts for the accumulator queue.
// ----------------------------------------------------------------------------
module mbfs_front
    import mbfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data,
    input  logic                 push,
    input  logic [WORD_BITS-1:0] read_word,
    input  logic                 last,
    output item_t                item
);

    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [WORD_BITS-1:0] pattern_reg, pattern_next;
    logic [WORD_BITS-1:0] expected_reg, expected_next;
    logic [WORD_BITS-1:0] diff;
    logic [INC_W-1:0]     exp_ones;
    logic [INC_W-1:0]     rd_ones;

    assign diff     = expected_reg ^ read_word;
    assign exp_ones = bits_set16(expected_reg);
    assign rd_ones  = bits_set16(read_word);

    always_comb
    begin
        item           = '0;
        item.last      = last;
        item.no_ref    = (mode_reg == MODE_NONE);
        case (mode_reg)
            MODE_CONST, MODE_ASCEND:
            begin
                item.flip_one  = bits_set16(diff & expected_reg);
                item.flip_zero = bits_set16(diff & read_word);
                item.ones      = exp_ones;
                item.zeros     = INC_W'(WORD_BITS) - exp_ones;
            end
            MODE_CENSUS:
            begin
                item.ones  = rd_ones;
                item.zeros = INC_W'(WORD_BITS) - rd_ones;
            end
            default:
            begin
                item.ones = '0;
            end
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        pattern_next  = pattern_reg;
        expected_next = expected_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_COMPARE_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                end
                REG_PATTERN_VALUE:
                begin
                    pattern_next  = cfg_data;
                    expected_next = cfg_data;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
        else if (push)
        begin
            if (last)
            begin
                expected_next = pattern_reg;
            end
            else if (mode_reg == MODE_ASCEND)
            begin
                expected_next = expected_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NONE;
            pattern_reg  <= '0;
            expected_reg <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            pattern_reg  <= pattern_next;
            expected_reg <= expected_next;
        end
    end

endmodule

FILE: design/mbfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_queue
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module mbfs_queue
    import mbfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  not_empty,
    output logic  full
);

    item_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg, count_next;

    assign head      = entries_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("queue pop while empty");

endmodule

FILE: design/mbfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_back
// Saturating accumulators and the result register; emits counts on the last
// word of a region and clears for the next one.
// ----------------------------------------------------------------------------
module mbfs_back
    import mbfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            head,
    input  logic             not_empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CNT_W-1:0] flipped_one_count,
    output logic [CNT_W-1:0] flipped_zero_count,
    output logic [CNT_W-1:0] one_count,
    output logic [CNT_W-1:0] zero_count,
    output logic             status
);

    logic [CNT_W-1:0] fo_acc_reg, fo_acc_next;
    logic [CNT_W-1:0] fz_acc_reg, fz_acc_next;
    logic [CNT_W-1:0] on_acc_reg, on_acc_next;
    logic [CNT_W-1:0] ze_acc_reg, ze_acc_next;
    logic [CNT_W-1:0] fo_sum, fz_sum, on_sum, ze_sum;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] fo_out_reg, fz_out_reg, on_out_reg, ze_out_reg;
    logic             status_reg;
    logic             slot_free;
    logic             emit;

    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = not_empty && (!head.last || slot_free);
    assign emit      = pop && head.last;

    assign fo_sum = sat_add(fo_acc_reg, head.flip_one);
    assign fz_sum = sat_add(fz_acc_reg, head.flip_zero);
    assign on_sum = sat_add(on_acc_reg, head.ones);
    assign ze_sum = sat_add(ze_acc_reg, head.zeros);

    always_comb
    begin
        fo_acc_next    = fo_acc_reg;
        fz_acc_next    = fz_acc_reg;
        on_acc_next    = on_acc_reg;
        ze_acc_next    = ze_acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            fo_acc_next    = '0;
            fz_acc_next    = '0;
            on_acc_next    = '0;
            ze_acc_next    = '0;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            fo_acc_next = fo_sum;
            fz_acc_next = fz_sum;
            on_acc_next = on_sum;
            ze_acc_next = ze_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fo_acc_reg    <= '0;
            fz_acc_reg    <= '0;
            on_acc_reg    <= '0;
            ze_acc_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fo_acc_reg    <= fo_acc_next;
            fz_acc_reg    <= fz_acc_next;
            on_acc_reg    <= on_acc_next;
            ze_acc_reg    <= ze_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (head.no_ref)
            begin
                fo_out_reg <= '0;
                fz_out_reg <= '0;
                on_out_reg <= '0;
                ze_out_reg <= '0;
                status_reg <= STATUS_NO_REF;
            end
            else
            begin
                fo_out_reg <= fo_sum;
                fz_out_reg <= fz_sum;
                on_out_reg <= on_sum;
                ze_out_reg <= ze_sum;
                status_reg <= STATUS_OK;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign flipped_one_count  = fo_out_reg;
    assign flipped_zero_count = fz_out_reg;
    assign one_count          = on_out_reg;
    assign zero_count         = ze_out_reg;
    assign status             = status_reg;

    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fo_acc_reg <= CNT_MAX && fz_acc_reg <= CNT_MAX &&
        on_acc_reg <= CNT_MAX && ze_acc_reg <= CNT_MAX)
        else $error("accumulator above saturation limit");

    a_no_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_NO_REF |->
            fo_out_reg == '0 && fz_out_reg == '0 && on_out_reg == '0 && ze_out_reg == '0)
        else $error("no-reference result carries counts");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> fo_acc_reg == '0 && fz_acc_reg == '0 &&
            on_acc_reg == '0 && ze_acc_reg == '0)
        else $error("accumulators not cleared after result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !emit)
        else $error("pending result overwritten");

endmodule

FILE: design/memory_bit_flip_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_bit_flip_statistics
// Compares read-back words with a constant or ascending pattern (or takes a
// census of the read data) and reports saturating bit counts per region.
// A result passes the queue and then the result register once its last word is
// taken. One word per cycle is taken while in_stall is low, set by the single
// accumulate stage behind the queue. Reset clears mode, pattern, expected word,
// accumulators and the result valid flag; no reference mode is active after it.
// ----------------------------------------------------------------------------
module memory_bit_flip_statistics
    import mbfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_BITS-1:0] read_word,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CNT_W-1:0]     flipped_one_count,
    output logic [CNT_W-1:0]     flipped_zero_count,
    output logic [CNT_W-1:0]     one_count,
    output logic [CNT_W-1:0]     zero_count,
    output logic                 status
);

    item_t front_item;
    item_t head;
    logic  push;
    logic  pop;
    logic  not_empty;
    logic  full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign push      = in_valid && !full;

    mbfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .read_word (read_word),
        .last      (last),
        .item      (front_item)
    );

    mbfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    mbfs_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (head),
        .not_empty          (not_empty),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .flipped_one_count  (flipped_one_count),
        .flipped_zero_count (flipped_zero_count),
        .one_count          (one_count),
        .zero_count         (zero_count),
        .status             (status)
    );

endmodule
